>>> sv/billboard_sprite_projection_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the checker file of the sprite projector.
// ---------------------------------------------------------------------------
`ifndef BILLBOARD_SPRITE_PROJECTION_MACROS_SVH
`define BILLBOARD_SPRITE_PROJECTION_MACROS_SVH

// Checked on every edge outside reset.
`define BSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/bsp_pkg.sv
// ---------------------------------------------------------------------------
// bsp_pkg
// Types and constants of the billboard sprite projector.
// ---------------------------------------------------------------------------
package bsp_pkg;

  // Camera and screen settings
  typedef struct packed {
    logic        [12:0] screen_width;
    logic        [12:0] screen_height;
    logic        [23:0] camera_x;
    logic        [23:0] camera_y;
    logic signed [17:0] view_dir_x;
    logic signed [17:0] view_dir_y;
    logic signed [17:0] cam_plane_x;
    logic signed [17:0] cam_plane_y;
  } cfg_t;

  // Register indexes on the write port
  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_CAMERA_X      = 3'd2,
    REG_CAMERA_Y      = 3'd3,
    REG_VIEW_DIR_X    = 3'd4,
    REG_VIEW_DIR_Y    = 3'd5,
    REG_CAM_PLANE_X   = 3'd6,
    REG_CAM_PLANE_Y   = 3'd7
  } reg_idx_t;

  // Camera-space terms handed from front to back
  typedef struct packed {
    logic signed [36:0] det;
    logic signed [43:0] nx;
    logic signed [43:0] ny;
    logic        [47:0] dsq;
  } proj_t;

  localparam int DIV_LAT = 33;   // latency of every divider

endpackage

>>> sv/bsp_div.sv
// ---------------------------------------------------------------------------
// bsp_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with an
// overflow flag when the quotient does not fit in QW bits.
// ---------------------------------------------------------------------------
module bsp_div #(
  parameter int NW  = 60,
  parameter int DW  = 36,
  parameter int QW  = 32,
  parameter int LAT = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);
  localparam int PAD = LAT - QW - 1;

  logic [DW-1:0] rem  [0:QW];
  logic [QW-1:0] qs   [0:QW];
  logic [QW-1:0] low  [0:QW];
  logic [DW-1:0] dn   [0:QW];
  logic          ov   [0:QW];

  // input stage: upper numerator bits seed the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(num[NW-1:QW]);
      low[0] <= num[QW-1:0];
      dn[0]  <= den;
      ov[0]  <= DW'(num[NW-1:QW]) >= den;
      qs[0]  <= '0;
    end
  end

  // one shift/subtract step per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem[k], low[k][QW-1-k]};
    assign ge    = trial >= {1'b0, dn[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? DW'(trial - {1'b0, dn[k]}) : trial[DW-1:0];
        qs[k+1]  <= {qs[k][QW-2:0], ge};
        low[k+1] <= low[k];
        dn[k+1]  <= dn[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  // padding so all dividers share one latency
  if (PAD > 0) begin : g_pad
    logic [QW-1:0] pq [0:PAD-1];
    logic          po [0:PAD-1];
    always_ff @(posedge clk) begin
      if (en) begin
        pq[0] <= qs[QW];
        po[0] <= ov[QW];
        for (int i = 1; i < PAD; i++) begin
          pq[i] <= pq[i-1];
          po[i] <= po[i-1];
        end
      end
    end
    assign quo = pq[PAD-1];
    assign ovf = po[PAD-1];
  end else begin : g_nopad
    assign quo = qs[QW];
    assign ovf = ov[QW];
  end

endmodule

>>> sv/bsp_queue.sv
// ---------------------------------------------------------------------------
// bsp_queue
// Small register FIFO between the front and back halves.
// ---------------------------------------------------------------------------
module bsp_queue import bsp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  proj_t push_data,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output proj_t head
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  proj_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

>>> sv/bsp_front.sv
// ---------------------------------------------------------------------------
// bsp_front
// Accepts sprite cells and forms the camera-space terms and distance.
// ---------------------------------------------------------------------------
module bsp_front import bsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,     // [7:0] sprite_x, [15:8] sprite_y
  input  logic        q_full,
  output logic        push,
  output proj_t       push_data
);
  logic en;
  logic v1, v2, v3;

  logic signed [24:0] sx_c, sy_c, ex_c, ey_c;
  logic signed [24:0] sx, sy, ex, ey;

  logic signed [42:0] p_dysx, p_dxsy, p_pxsy, p_pysx;
  logic signed [35:0] p_pxdy, p_dxpy;
  logic signed [49:0] p_exex, p_eyey;
  logic        [49:0] dsq_sum;

  proj_t out_r;

  assign en       = !q_full;
  assign s_tready = en;
  assign push     = v3 && en;
  assign push_data = out_r;

  // cell centre and corner relative to the camera
  assign sx_c = 25'({1'b0, s_tdata[7:0], 16'h8000}) - 25'({1'b0, cfg.camera_x});
  assign sy_c = 25'({1'b0, s_tdata[15:8], 16'h8000}) - 25'({1'b0, cfg.camera_y});
  assign ex_c = 25'({1'b0, cfg.camera_x}) - 25'({1'b0, s_tdata[7:0], 16'h0000});
  assign ey_c = 25'({1'b0, cfg.camera_y}) - 25'({1'b0, s_tdata[15:8], 16'h0000});

  assign dsq_sum = 50'(p_exex[48:0]) + 50'(p_eyey[48:0]);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // offsets, products, then combine
  always_ff @(posedge clk) begin
    if (en) begin
      sx <= sx_c;
      sy <= sy_c;
      ex <= ex_c;
      ey <= ey_c;

      p_dysx <= 43'(cfg.view_dir_y) * 43'(sx);
      p_dxsy <= 43'(cfg.view_dir_x) * 43'(sy);
      p_pxsy <= 43'(cfg.cam_plane_x) * 43'(sy);
      p_pysx <= 43'(cfg.cam_plane_y) * 43'(sx);
      p_pxdy <= 36'(cfg.cam_plane_x) * 36'(cfg.view_dir_y);
      p_dxpy <= 36'(cfg.view_dir_x) * 36'(cfg.cam_plane_y);
      p_exex <= 50'(ex) * 50'(ex);
      p_eyey <= 50'(ey) * 50'(ey);

      out_r.det <= 37'(p_pxdy) - 37'(p_dxpy);
      out_r.nx  <= 44'(p_dysx) - 44'(p_dxsy);
      out_r.ny  <= 44'(p_pxsy) - 44'(p_pysx);
      out_r.dsq <= (dsq_sum[49:48] != 2'b00) ? '1 : dsq_sum[47:0];
    end
  end

endmodule

>>> sv/bsp_back.sv
// ---------------------------------------------------------------------------
// bsp_back
// Divides out depth, centre column and size, clamps the drawing bounds and
// holds the result beat.
// ---------------------------------------------------------------------------
module bsp_back import bsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  proj_t        head,
  input  logic         empty,
  output logic         pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata,   // depth, centre_column, sprite_height,
                                  // sprite_width, first_column, last_column,
                                  // first_row, last_row, distance_sq, zero pad
  output logic         m_tuser    // in_front
);
  typedef struct packed {
    logic        special;
    logic        neg_d;
    logic        neg_c;
    logic [47:0] dsq;
  } side_t;

  logic en;

  // operand stage
  logic [43:0] any_c;
  logic [35:0] adet_c;
  logic signed [44:0] nsum_c;
  logic [44:0] ansum_c;
  logic [11:0] half_rx;
  logic [11:0] half_ry;

  logic        b1_v;
  side_t       b1_side;
  logic [59:0] num_d;
  logic [35:0] den_d;
  logic [56:0] num_c;
  logic [43:0] den_c;
  logic [48:0] num_s;

  // divider outputs and aligned side data
  logic [31:0] q_d;
  logic [23:0] q_c;
  logic [15:0] q_s;
  logic        o_d, o_c, o_s;
  logic [DIV_LAT-1:0] sb_v;
  side_t       sb [DIV_LAT];

  // finished values
  logic               c1_v;
  logic signed [31:0] depth_c, depth;
  logic signed [23:0] centre_c, centre;
  logic        [15:0] size_c, size;
  logic        [47:0] dsq;
  logic        [32:0] qd_s;
  logic        [24:0] qc_s;

  // bounds
  logic        [14:0] hs;
  logic signed [16:0] fr_t;
  logic        [15:0] lr_t;
  logic signed [24:0] fc_t, lc_t;
  logic        [11:0] fr;
  logic        [12:0] lr;
  logic        [15:0] fc;
  logic        [16:0] lc;

  assign en  = !m_tvalid || m_tready;
  assign pop = en && !empty;

  assign half_rx = cfg.screen_width[12:1];
  assign half_ry = cfg.screen_height[12:1];

  // magnitudes of the queued terms
  assign nsum_c  = 45'(head.nx) + 45'(head.ny);
  assign any_c   = head.ny[43] ? 44'(-head.ny) : 44'(head.ny);
  assign adet_c  = head.det[36] ? 36'(-head.det) : 36'(head.det);
  assign ansum_c = nsum_c[44] ? 45'(-nsum_c) : 45'(nsum_c);

  always_ff @(posedge clk) begin
    if (rst) b1_v <= 1'b0;
    else if (en) b1_v <= pop;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_side.special <= (head.det == '0) || (head.ny == '0);
      b1_side.neg_d   <= head.ny[43] ^ head.det[36];
      b1_side.neg_c   <= nsum_c[44] ^ head.ny[43];
      b1_side.dsq     <= head.dsq;
      num_d <= {any_c, 16'h0000};
      den_d <= adet_c;
      num_c <= 57'(half_rx) * 57'(ansum_c);
      den_c <= any_c;
      num_s <= 49'(cfg.screen_height) * 49'(adet_c);
    end
  end

  bsp_div #(.NW(60), .DW(36), .QW(32), .LAT(DIV_LAT)) u_div_depth (
    .clk(clk), .en(en), .num(num_d), .den(den_d), .quo(q_d), .ovf(o_d));
  bsp_div #(.NW(57), .DW(44), .QW(24), .LAT(DIV_LAT)) u_div_centre (
    .clk(clk), .en(en), .num(num_c), .den(den_c), .quo(q_c), .ovf(o_c));
  bsp_div #(.NW(49), .DW(44), .QW(16), .LAT(DIV_LAT)) u_div_size (
    .clk(clk), .en(en), .num(num_s), .den(den_c), .quo(q_s), .ovf(o_s));

  // side data travels beside the dividers
  always_ff @(posedge clk) begin
    if (rst) sb_v <= '0;
    else if (en) sb_v <= {sb_v[DIV_LAT-2:0], b1_v};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= b1_side;
      for (int i = 1; i < DIV_LAT; i++) sb[i] <= sb[i-1];
    end
  end

  // sign, saturation and the singular case
  assign qd_s = sb[DIV_LAT-1].neg_d ? 33'(-{1'b0, q_d}) : {1'b0, q_d};
  assign qc_s = sb[DIV_LAT-1].neg_c ? 25'(-{1'b0, q_c}) : {1'b0, q_c};

  always_comb begin
    if (sb[DIV_LAT-1].special) begin
      depth_c  = '0;
      centre_c = 24'(half_rx);
      size_c   = '1;
    end else begin
      if (sb[DIV_LAT-1].neg_d) begin
        depth_c = (o_d || q_d > 32'h8000_0000) ? 32'sh8000_0000 : qd_s[31:0];
      end else begin
        depth_c = (o_d || q_d[31]) ? 32'sh7FFF_FFFF : qd_s[31:0];
      end
      if (sb[DIV_LAT-1].neg_c) begin
        centre_c = (o_c || q_c > 24'h80_0000) ? 24'sh80_0000 : qc_s[23:0];
      end else begin
        centre_c = (o_c || q_c[23]) ? 24'sh7F_FFFF : qc_s[23:0];
      end
      size_c = o_s ? 16'hFFFF : q_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c1_v <= 1'b0;
    else if (en) c1_v <= sb_v[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth  <= depth_c;
      centre <= centre_c;
      size   <= size_c;
      dsq    <= sb[DIV_LAT-1].dsq;
    end
  end

  // drawing bounds
  assign hs   = size[15:1];
  assign fr_t = 17'({5'b0, half_ry}) - 17'({2'b0, hs});
  assign lr_t = 16'(half_ry) + 16'(hs);
  assign fc_t = 25'(centre) - 25'({1'b0, hs});
  assign lc_t = 25'(centre) + 25'({1'b0, hs});

  always_comb begin
    fr = fr_t[16] ? '0 : fr_t[11:0];
    lr = (lr_t >= 16'(cfg.screen_height)) ? cfg.screen_height : lr_t[12:0];
    if (fc_t[24])                    fc = '0;
    else if (fc_t > 25'sd65535)      fc = 16'hFFFF;
    else                             fc = fc_t[15:0];
    if (lc_t >= $signed(25'({1'b0, cfg.screen_width}))) lc = 17'(cfg.screen_width);
    else if (lc_t < -25'sd65536)     lc = 17'h1_0000;
    else                             lc = lc_t[16:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= c1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= !depth[31] && (depth != '0);
      m_tdata <= {6'b0, dsq, lr, fr, lc, fc, size, size, centre, depth};
    end
  end

endmodule

>>> sv/billboard_sprite_projection.sv
// ---------------------------------------------------------------------------
// billboard_sprite_projection
// Projects a sprite's map cell into camera space and screen bounds.
// ---------------------------------------------------------------------------
//  channel  direction  payload
//  s_*      in         sprite_x, sprite_y
//  m_*      out        tuser: in_front; tdata: depth .. distance_sq
//  cfg_*    in         register index and write data
//
// One sprite per cycle sustained while the output does not stall; the path
// is 3 front stages, queue, operand stage, 33-stage dividers, 2 final stages.
// The depth divider, one quotient bit per stage over 32 bits, sets latency.
// Synchronous reset restores the default camera and empties the pipe.
// A stalled output freezes the back half; the front runs on until the
// queue fills, then drops s_tready.
// ---------------------------------------------------------------------------
module billboard_sprite_projection import bsp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,    // [7:0] sprite_x, [15:8] sprite_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata,    // depth, centre_column, sprite_height,
                                   // sprite_width, first_column, last_column,
                                   // first_row, last_row, distance_sq, pad
  output logic         m_tuser,    // in_front
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_wdata
);
  cfg_t  cfg;
  logic  q_full, q_empty, push, pop;
  proj_t push_data, head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 13'd640;
      cfg.screen_height <= 13'd480;
      cfg.camera_x      <= '0;
      cfg.camera_y      <= '0;
      cfg.view_dir_x    <= 18'sd65536;
      cfg.view_dir_y    <= '0;
      cfg.cam_plane_x   <= '0;
      cfg.cam_plane_y   <= 18'sd43254;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_wdata[12:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_wdata[12:0];
        REG_CAMERA_X:      cfg.camera_x      <= cfg_wdata;
        REG_CAMERA_Y:      cfg.camera_y      <= cfg_wdata;
        REG_VIEW_DIR_X:    cfg.view_dir_x    <= cfg_wdata[17:0];
        REG_VIEW_DIR_Y:    cfg.view_dir_y    <= cfg_wdata[17:0];
        REG_CAM_PLANE_X:   cfg.cam_plane_x   <= cfg_wdata[17:0];
        REG_CAM_PLANE_Y:   cfg.cam_plane_y   <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  bsp_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .q_full(q_full), .push(push), .push_data(push_data));

  bsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .full(q_full), .empty(q_empty), .head(head));

  bsp_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .empty(q_empty), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser));

endmodule

>>> sv/bsp_checker.sv
// ---------------------------------------------------------------------------
// bsp_checker
// Port-level checks on the sprite projector's result stream.
// ---------------------------------------------------------------------------
`include "billboard_sprite_projection_macros.svh"

module bsp_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [199:0] m_tdata,
  input logic         m_tuser
);

  // a stalled beat holds
  `BSP_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "beat changed under stall")

  // reset empties the output
  `BSP_ASSERT_ALWAYS(a_rst, rst |=> !m_tvalid, "output valid after reset")

  // in_front flag agrees with the sign of depth
  `BSP_ASSERT(a_front, m_tvalid |-> (m_tuser == (!m_tdata[31] && (m_tdata[31:0] != 32'd0))), "in_front does not match depth")

  // height and width are the same size
  `BSP_ASSERT(a_square, m_tvalid |-> (m_tdata[71:56] == m_tdata[87:72]), "height and width differ")

endmodule

bind billboard_sprite_projection bsp_checker u_bsp_checker (.*);
